// ----- hdl/rpc_pkg.sv -----
`timescale 1ns / 1ps
// rpc_pkg: shared constants and types of the rotated 2x2 pattern counter
// no dependencies

package rpc_pkg;

    localparam int MAX_SIZE = 64;
    localparam int COL_W    = $clog2(MAX_SIZE);
    localparam int SIZE_W   = COL_W + 1;
    localparam int GRID_W   = 7;
    localparam int PIX_W    = 8;
    localparam int CNT_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE    = 3'd0,
        CFG_PAT_TOP_L    = 3'd1,
        CFG_PAT_TOP_R    = 3'd2,
        CFG_PAT_BOTTOM_L = 3'd3,
        CFG_PAT_BOTTOM_R = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] br;
    } pattern_t;

    typedef struct packed {
        logic win;
        logic last;
    } pos_tag_t;

endpackage

// ----- hdl/rotated_2x2_pattern_counter_core.sv -----
`timescale 1ns / 1ps
// rotated_2x2_pattern_counter_core: top level, configuration registers and row store
// depends on rpc_pkg, rpc_ram, rpc_addr, rpc_match

// Takes one pixel word per clock. Each accepted pixel reads and writes its column of
// a 64 x 8 row store ram at the same edge; the window compare and count update use
// the compare stage register, so the sustained rate is one pixel per cycle while not
// stalled. The four counts go on the result channel as the last pixel of a grid
// leaves the compare stage; a pending result word stalls the input only when the next
// grid's last pixel reaches the compare stage. No clearing pass is needed after reset.
// Configuration writes are taken every cycle and must only be made while idle.

module rotated_2x2_pattern_counter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rpc_pkg::PIX_W-1:0]     s_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rpc_pkg::CNT_W-1:0]     m_count_rot0,
    output logic [rpc_pkg::CNT_W-1:0]     m_count_rot90,
    output logic [rpc_pkg::CNT_W-1:0]     m_count_rot180,
    output logic [rpc_pkg::CNT_W-1:0]     m_count_rot270
);

    logic [rpc_pkg::GRID_W-1:0] grid_size_reg;
    rpc_pkg::pattern_t          pattern_reg;
    logic                       accept;
    logic                       take_ok;
    logic [rpc_pkg::COL_W-1:0]  col;
    rpc_pkg::pos_tag_t          tag;
    logic [rpc_pkg::PIX_W-1:0]  above;

    assign cfg_ready = 1'b1;
    assign s_ready   = take_ok;
    assign accept    = s_valid && take_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= rpc_pkg::GRID_W'(2);
            pattern_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rpc_pkg::CFG_GRID_SIZE:    grid_size_reg  <= cfg_data[rpc_pkg::GRID_W-1:0];
                rpc_pkg::CFG_PAT_TOP_L:    pattern_reg.tl <= cfg_data;
                rpc_pkg::CFG_PAT_TOP_R:    pattern_reg.tr <= cfg_data;
                rpc_pkg::CFG_PAT_BOTTOM_L: pattern_reg.bl <= cfg_data;
                rpc_pkg::CFG_PAT_BOTTOM_R: pattern_reg.br <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    rpc_addr u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .grid_size (grid_size_reg),
        .col       (col),
        .tag       (tag)
    );

    rpc_ram #(
        .WIDTH (rpc_pkg::PIX_W),
        .DEPTH (rpc_pkg::MAX_SIZE)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col),
        .wr_data (s_pixel),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (above)
    );

    rpc_match u_match (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .pixel          (s_pixel),
        .tag            (tag),
        .above          (above),
        .pattern        (pattern_reg),
        .take_ok        (take_ok),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_count_rot0   (m_count_rot0),
        .m_count_rot90  (m_count_rot90),
        .m_count_rot180 (m_count_rot180),
        .m_count_rot270 (m_count_rot270)
    );

endmodule

// ----- hdl/rpc_ram.sv -----
`timescale 1ns / 1ps
// rpc_ram: generic single-port-write, single-port-read ram with registered read
// read returns the old word when read and write hit the same entry

module rpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/rpc_addr.sv -----
`timescale 1ns / 1ps
// rpc_addr: row and column position counters, row store address and window tags
// depends on rpc_pkg

module rpc_addr (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [rpc_pkg::GRID_W-1:0] grid_size,
    output logic [rpc_pkg::COL_W-1:0]  col,
    output rpc_pkg::pos_tag_t          tag
);

    logic [rpc_pkg::COL_W-1:0]  col_reg, col_next;
    logic [rpc_pkg::COL_W-1:0]  row_reg, row_next;
    logic [rpc_pkg::SIZE_W-1:0] size;
    logic [rpc_pkg::SIZE_W-1:0] col_inc;
    logic [rpc_pkg::SIZE_W-1:0] row_inc;
    logic                       col_wrap;
    logic                       last;

    always_comb begin
        if (grid_size == '0) begin
            size = rpc_pkg::SIZE_W'(1);
        end else if (32'(grid_size) > rpc_pkg::MAX_SIZE) begin
            size = rpc_pkg::SIZE_W'(rpc_pkg::MAX_SIZE);
        end else begin
            size = rpc_pkg::SIZE_W'(grid_size);
        end
    end

    assign col_inc  = {1'b0, col_reg} + rpc_pkg::SIZE_W'(1);
    assign row_inc  = {1'b0, row_reg} + rpc_pkg::SIZE_W'(1);
    assign col_wrap = (col_inc >= size);
    assign last     = col_wrap && (row_inc >= size);

    assign tag = '{win: (row_reg != '0) && (col_reg != '0), last: last};
    assign col = col_reg;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (!col_wrap) begin
                col_next = col_inc[rpc_pkg::COL_W-1:0];
            end else begin
                col_next = '0;
                row_next = last ? '0 : row_inc[rpc_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- hdl/rpc_match.sv -----
`timescale 1ns / 1ps
// rpc_match: window compare against four pattern rotations, match counters, result word
// depends on rpc_pkg

module rpc_match (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      accept,
    input  logic [rpc_pkg::PIX_W-1:0] pixel,
    input  rpc_pkg::pos_tag_t         tag,
    input  logic [rpc_pkg::PIX_W-1:0] above,
    input  rpc_pkg::pattern_t         pattern,
    output logic                      take_ok,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [rpc_pkg::CNT_W-1:0] m_count_rot0,
    output logic [rpc_pkg::CNT_W-1:0] m_count_rot90,
    output logic [rpc_pkg::CNT_W-1:0] m_count_rot180,
    output logic [rpc_pkg::CNT_W-1:0] m_count_rot270
);

    logic                      s1_valid_reg, s1_valid_next;
    logic [rpc_pkg::PIX_W-1:0] s1_px_reg;
    rpc_pkg::pos_tag_t         s1_tag_reg;
    logic [rpc_pkg::PIX_W-1:0] left_reg;
    logic [rpc_pkg::PIX_W-1:0] ul_reg;
    logic [rpc_pkg::CNT_W-1:0] cnt_reg [4];
    logic [rpc_pkg::CNT_W-1:0] cnt_next [4];
    logic [rpc_pkg::CNT_W-1:0] cnt_upd [4];
    logic [rpc_pkg::CNT_W-1:0] out_reg [4];
    logic                      m_valid_reg, m_valid_next;
    rpc_pkg::pattern_t         rot [4];
    rpc_pkg::pattern_t         window;
    logic                      advance;

    // clockwise turns of the pattern
    always_comb begin
        rot[0] = pattern;
        rot[1] = '{tl: pattern.bl, tr: pattern.tl, bl: pattern.br, br: pattern.tr};
        rot[2] = '{tl: pattern.br, tr: pattern.bl, bl: pattern.tr, br: pattern.tl};
        rot[3] = '{tl: pattern.tr, tr: pattern.br, bl: pattern.tl, br: pattern.bl};
    end

    assign window  = '{tl: ul_reg, tr: above, bl: left_reg, br: s1_px_reg};
    assign advance = s1_valid_reg && (!s1_tag_reg.last || !m_valid_reg || m_ready);
    assign take_ok = !s1_valid_reg || advance;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            cnt_upd[k] = cnt_reg[k];
            if (s1_tag_reg.win && (window == rot[k]) && (cnt_reg[k] != '1)) begin
                cnt_upd[k] = cnt_reg[k] + rpc_pkg::CNT_W'(1);
            end
            cnt_next[k] = cnt_reg[k];
            if (advance) begin
                cnt_next[k] = s1_tag_reg.last ? '0 : cnt_upd[k];
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance && s1_tag_reg.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            left_reg     <= '0;
            ul_reg       <= '0;
            for (int k = 0; k < 4; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                left_reg <= s1_px_reg;
                ul_reg   <= above;
            end
            for (int k = 0; k < 4; k++) begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg  <= pixel;
            s1_tag_reg <= tag;
        end
        if (advance && s1_tag_reg.last) begin
            for (int k = 0; k < 4; k++) begin
                out_reg[k] <= cnt_upd[k];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_count_rot0   = out_reg[0];
    assign m_count_rot90  = out_reg[1];
    assign m_count_rot180 = out_reg[2];
    assign m_count_rot270 = out_reg[3];

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (!s1_valid_reg || advance))
        else $error("pixel taken while stage one is stalled");

    a_last_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_tag_reg.last && m_valid_reg && !m_ready) |=> s1_valid_reg)
        else $error("last pixel dropped while result word pending");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && s1_tag_reg.last) |=> (cnt_reg[0] == '0 && cnt_reg[1] == '0
            && cnt_reg[2] == '0 && cnt_reg[3] == '0))
        else $error("counts not cleared after result word");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg && s1_tag_reg.last))
        else $error("result word without last pixel");

endmodule
